// ===== rtl/core/lobm_pkg.sv =====
// Shared types, codes and helpers of the limit order book matcher.
// Depends on nothing; every other file of the block refers to it by scoped names.
package lobm_pkg;

	localparam int MAX_ORDERS_DEF = 64;
	localparam int RESULT_LIMIT   = 64;
	localparam int TRADE_LIMIT    = RESULT_LIMIT - 1;
	localparam int NTR_W          = $clog2(RESULT_LIMIT);

	// Input action codes.
	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_MODIFY = 2'd2;

	// Result kinds.
	localparam logic [2:0] KIND_TRADE     = 3'd0;
	localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
	localparam logic [2:0] KIND_DUPLICATE = 3'd2;
	localparam logic [2:0] KIND_NO_CROSS  = 3'd3;
	localparam logic [2:0] KIND_CANCELLED = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN   = 3'd5;
	localparam logic [2:0] KIND_INVALID   = 3'd6;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        order_id;
		logic               side;
		logic signed [31:0] price;
		logic [23:0]        quantity;
		logic               order_type;
	} order_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        bid_order_id;
		logic [31:0]        ask_order_id;
		logic signed [31:0] bid_price;
		logic signed [31:0] ask_price;
		logic [23:0]        fill_quantity;
		logic               last;
	} report_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_CANCEL,
		OP_MODIFY,
		OP_BAD
	} op_t;

	// Classified command handed from the front to the engine.
	typedef struct packed {
		op_t                op;
		logic [31:0]        id;
		logic               side;
		logic signed [31:0] price;
		logic [23:0]        qty;
		logic               fak;
		logic               qty_zero;
	} cmd_t;

	typedef struct packed {
		logic [31:0]        id;
		logic               side;
		logic               fak;
		logic signed [31:0] price;
		logic [23:0]        remaining;
		logic [31:0]        arrival;
	} entry_t;

	typedef enum logic [1:0] {
		SCAN_FIND,
		SCAN_ADD,
		SCAN_MATCH
	} scan_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_FIND_DONE,
		S_ADD_CHECK,
		S_ADD_DONE,
		S_MATCH_DONE,
		S_TRADE_B,
		S_TRADE_A,
		S_EMIT
	} eng_state_t;

	function automatic report_t status(input logic [2:0] kind, input logic [31:0] id);
		report_t r;
		r.kind          = kind;
		r.bid_order_id  = id;
		r.ask_order_id  = '0;
		r.bid_price     = '0;
		r.ask_price     = '0;
		r.fill_quantity = '0;
		r.last          = 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/core/lobm_front.sv =====
// Front of the matcher: takes input transfers, classifies them and queues them.
// Depends on lobm_pkg.
module lobm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  lobm_pkg::order_t  order,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output lobm_pkg::cmd_t    cmd
);

	lobm_pkg::cmd_t slot_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	lobm_pkg::cmd_t cls;
	logic           do_push, do_pop;

	always_comb begin
		cls.id       = order.order_id;
		cls.side     = order.side;
		cls.price    = order.price;
		cls.qty      = order.quantity;
		cls.fak      = order.order_type;
		cls.qty_zero = (order.quantity == '0);
		unique case (order.action)
			lobm_pkg::ACT_ADD:    cls.op = lobm_pkg::OP_ADD;
			lobm_pkg::ACT_CANCEL: cls.op = lobm_pkg::OP_CANCEL;
			lobm_pkg::ACT_MODIFY: cls.op = lobm_pkg::OP_MODIFY;
			default:              cls.op = lobm_pkg::OP_BAD;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/lobm_resq.sv =====
// Result queue of the matcher: holds reports until the consumer pops them.
// Depends on lobm_pkg.
module lobm_resq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lobm_pkg::report_t  in_report,
	output logic               empty,
	input  logic               pop,
	output lobm_pkg::report_t  report
);

	lobm_pkg::report_t slot_q [4];
	logic [1:0]        wp_q, rp_q;
	logic [2:0]        cnt_q;
	logic              do_push, do_pop;

	assign in_ready = (cnt_q != 3'd4);
	assign empty    = (cnt_q == 3'd0);
	assign report   = slot_q[rp_q];
	assign do_push  = in_valid && in_ready;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= in_report;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, do_push} - {2'b0, do_pop};
		end
	end

endmodule

// ===== rtl/core/lobm_engine.sv =====
// Back of the matcher: the order memory, the scanning search and the matching sequencer.
// Depends on lobm_pkg.
module lobm_engine #(
	parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  lobm_pkg::cmd_t     cmd,
	output logic               res_valid,
	input  logic               res_ready,
	output lobm_pkg::report_t  res
);

	localparam int IW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
	localparam int CW = IW + 1;

	lobm_pkg::eng_state_t state_q, state_d;
	lobm_pkg::scan_t      purpose_q, scan_kind;
	logic                 scan_go;

	lobm_pkg::entry_t     book_mem [MAX_ORDERS];
	lobm_pkg::entry_t     rdata_q, wdata;
	logic [IW-1:0]        waddr;
	logic                 we;

	logic [MAX_ORDERS-1:0] valid_q;
	logic [CW-1:0]         cnt_q;
	logic                  rv_s1;
	logic [IW-1:0]         idx_s1;
	logic                  scan_done;

	lobm_pkg::cmd_t     cmd_q;
	logic               fak_q;
	logic               found_q, found_fak_q, free_found_q, hb_q, ha_q;
	logic [IW-1:0]      found_idx_q, free_idx_q, bb_idx_q, ba_idx_q, slot_q;
	lobm_pkg::entry_t   bb_q, ba_q;
	logic [31:0]        ctr_q;
	logic [lobm_pkg::NTR_W-1:0] ntr_q;
	logic [23:0]        fill_q;
	lobm_pkg::report_t  rep_q;

	// Candidate evaluation of the entry returned by the memory.
	logic               ev_valid;
	logic [31:0]        age_e, age_b, age_a;
	logic               bid_better, ask_better;
	logic               crosses_best, add_ok, trade_go;
	logic [23:0]        fill_d;

	assign ev_valid  = valid_q[idx_s1];
	assign age_e     = ctr_q - rdata_q.arrival;
	assign age_b     = ctr_q - bb_q.arrival;
	assign age_a     = ctr_q - ba_q.arrival;
	assign bid_better = !hb_q || ($signed(rdata_q.price) > $signed(bb_q.price)) ||
		((rdata_q.price == bb_q.price) && (age_e > age_b));
	assign ask_better = !ha_q || ($signed(rdata_q.price) < $signed(ba_q.price)) ||
		((rdata_q.price == ba_q.price) && (age_e > age_a));
	assign scan_done = (cnt_q == CW'(MAX_ORDERS)) && !rv_s1;

	// A buy crosses the best ask at or below its limit, a sell the best bid at or above.
	assign crosses_best = cmd_q.side ? (hb_q && ($signed(cmd_q.price) <= $signed(bb_q.price)))
	                                 : (ha_q && ($signed(cmd_q.price) >= $signed(ba_q.price)));
	assign add_ok   = !found_q && !(fak_q && !crosses_best) && free_found_q;
	assign trade_go = (ntr_q < lobm_pkg::NTR_W'(lobm_pkg::TRADE_LIMIT)) && hb_q && ha_q &&
		($signed(bb_q.price) >= $signed(ba_q.price));
	assign fill_d   = (bb_q.remaining < ba_q.remaining) ? bb_q.remaining : ba_q.remaining;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lobm_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						lobm_pkg::OP_ADD:    state_d = lobm_pkg::S_ADD_CHECK;
						lobm_pkg::OP_BAD:    state_d = lobm_pkg::S_EMIT;
						default:             state_d = lobm_pkg::S_SCAN;
					endcase
				end
			end
			lobm_pkg::S_SCAN: begin
				if (scan_done) begin
					unique case (purpose_q)
						lobm_pkg::SCAN_FIND: state_d = lobm_pkg::S_FIND_DONE;
						lobm_pkg::SCAN_ADD:  state_d = lobm_pkg::S_ADD_DONE;
						default:             state_d = lobm_pkg::S_MATCH_DONE;
					endcase
				end
			end
			lobm_pkg::S_FIND_DONE: begin
				if (!found_q || cmd_q.op == lobm_pkg::OP_CANCEL) begin
					state_d = lobm_pkg::S_EMIT;
				end else begin
					state_d = lobm_pkg::S_ADD_CHECK;
				end
			end
			lobm_pkg::S_ADD_CHECK: begin
				state_d = cmd_q.qty_zero ? lobm_pkg::S_EMIT : lobm_pkg::S_SCAN;
			end
			lobm_pkg::S_ADD_DONE: begin
				state_d = add_ok ? lobm_pkg::S_SCAN : lobm_pkg::S_EMIT;
			end
			lobm_pkg::S_MATCH_DONE: begin
				state_d = trade_go ? lobm_pkg::S_TRADE_B : lobm_pkg::S_EMIT;
			end
			lobm_pkg::S_TRADE_B: state_d = lobm_pkg::S_TRADE_A;
			lobm_pkg::S_TRADE_A: state_d = lobm_pkg::S_EMIT;
			lobm_pkg::S_EMIT: begin
				if (res_ready) begin
					state_d = rep_q.last ? lobm_pkg::S_IDLE : lobm_pkg::S_SCAN;
				end
			end
			default: state_d = lobm_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		scan_go   = 1'b0;
		scan_kind = lobm_pkg::SCAN_MATCH;
		we        = 1'b0;
		waddr     = bb_idx_q;
		wdata     = bb_q;
		unique case (state_q)
			lobm_pkg::S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid && (cmd.op == lobm_pkg::OP_CANCEL || cmd.op == lobm_pkg::OP_MODIFY)) begin
					scan_go   = 1'b1;
					scan_kind = lobm_pkg::SCAN_FIND;
				end
			end
			lobm_pkg::S_ADD_CHECK: begin
				scan_go   = !cmd_q.qty_zero;
				scan_kind = lobm_pkg::SCAN_ADD;
			end
			lobm_pkg::S_ADD_DONE: begin
				scan_go         = add_ok;
				we              = add_ok;
				waddr           = free_idx_q;
				wdata.id        = cmd_q.id;
				wdata.side      = cmd_q.side;
				wdata.fak       = fak_q;
				wdata.price     = cmd_q.price;
				wdata.remaining = cmd_q.qty;
				wdata.arrival   = ctr_q;
			end
			lobm_pkg::S_TRADE_B: begin
				we = 1'b1;
			end
			lobm_pkg::S_TRADE_A: begin
				we    = 1'b1;
				waddr = ba_idx_q;
				wdata = ba_q;
			end
			lobm_pkg::S_EMIT: begin
				res_valid = 1'b1;
				scan_go   = res_ready && !rep_q.last;
			end
			default: begin
			end
		endcase
	end

	assign res = rep_q;

	always_ff @(posedge clk) begin
		if (we) begin
			book_mem[waddr] <= wdata;
		end
		rdata_q <= book_mem[cnt_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lobm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purpose_q    <= lobm_pkg::SCAN_FIND;
			cnt_q        <= '0;
			rv_s1        <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			found_fak_q  <= 1'b0;
			found_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			hb_q         <= 1'b0;
			ha_q         <= 1'b0;
			bb_q         <= '0;
			ba_q         <= '0;
			bb_idx_q     <= '0;
			ba_idx_q     <= '0;
			valid_q      <= '0;
			ctr_q        <= '0;
			ntr_q        <= '0;
			slot_q       <= '0;
			fak_q        <= 1'b0;
			cmd_q        <= '0;
			fill_q       <= '0;
			rep_q        <= '0;
		end else begin
			// Scan: one address issued per cycle, judged when its data returns.
			if (scan_go) begin
				purpose_q    <= scan_kind;
				cnt_q        <= '0;
				rv_s1        <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				hb_q         <= 1'b0;
				ha_q         <= 1'b0;
			end else if (state_q == lobm_pkg::S_SCAN) begin
				rv_s1  <= (cnt_q != CW'(MAX_ORDERS));
				idx_s1 <= cnt_q[IW-1:0];
				if (cnt_q != CW'(MAX_ORDERS)) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (rv_s1) begin
					if (ev_valid && !found_q && rdata_q.id == cmd_q.id) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_s1;
						found_fak_q <= rdata_q.fak;
					end
					if (!ev_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_s1;
					end
					if (ev_valid && !rdata_q.side && bid_better) begin
						hb_q     <= 1'b1;
						bb_q     <= rdata_q;
						bb_idx_q <= idx_s1;
					end
					if (ev_valid && rdata_q.side && ask_better) begin
						ha_q     <= 1'b1;
						ba_q     <= rdata_q;
						ba_idx_q <= idx_s1;
					end
				end
			end

			unique case (state_q)
				lobm_pkg::S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						fak_q <= cmd.fak;
						if (cmd.op == lobm_pkg::OP_BAD) begin
							rep_q <= lobm_pkg::status(lobm_pkg::KIND_INVALID, cmd.id);
						end
					end
				end
				lobm_pkg::S_FIND_DONE: begin
					if (!found_q) begin
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_UNKNOWN, cmd_q.id);
					end else begin
						valid_q[found_idx_q] <= 1'b0;
						fak_q <= found_fak_q;
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_CANCELLED, cmd_q.id);
					end
				end
				lobm_pkg::S_ADD_CHECK: begin
					rep_q <= lobm_pkg::status(lobm_pkg::KIND_INVALID, cmd_q.id);
				end
				lobm_pkg::S_ADD_DONE: begin
					if (found_q) begin
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_DUPLICATE, cmd_q.id);
					end else if (fak_q && !crosses_best) begin
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_NO_CROSS, cmd_q.id);
					end else if (!free_found_q) begin
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_INVALID, cmd_q.id);
					end else begin
						valid_q[free_idx_q] <= 1'b1;
						slot_q <= free_idx_q;
						ctr_q  <= ctr_q + 32'd1;
						ntr_q  <= '0;
					end
				end
				lobm_pkg::S_MATCH_DONE: begin
					if (trade_go) begin
						bb_q.remaining <= bb_q.remaining - fill_d;
						ba_q.remaining <= ba_q.remaining - fill_d;
						fill_q         <= fill_d;
					end else if (valid_q[slot_q] && fak_q) begin
						// The unfilled rest of a fill-and-kill order leaves the book.
						valid_q[slot_q] <= 1'b0;
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_CANCELLED, cmd_q.id);
					end else begin
						rep_q <= lobm_pkg::status(lobm_pkg::KIND_ACCEPTED, cmd_q.id);
					end
				end
				lobm_pkg::S_TRADE_B: begin
					if (bb_q.remaining == '0) begin
						valid_q[bb_idx_q] <= 1'b0;
					end
				end
				lobm_pkg::S_TRADE_A: begin
					if (ba_q.remaining == '0) begin
						valid_q[ba_idx_q] <= 1'b0;
					end
					ntr_q <= ntr_q + lobm_pkg::NTR_W'(1);
					rep_q.kind          <= lobm_pkg::KIND_TRADE;
					rep_q.bid_order_id  <= bb_q.id;
					rep_q.ask_order_id  <= ba_q.id;
					rep_q.bid_price     <= bb_q.price;
					rep_q.ask_price     <= ba_q.price;
					rep_q.fill_quantity <= fill_q;
					rep_q.last          <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	a_trade_sides: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::S_TRADE_B |-> !bb_q.side && ba_q.side && bb_idx_q != ba_idx_q)
		else $error("trade pairs orders of the wrong sides");
	a_trade_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::S_TRADE_B |=> state_q == lobm_pkg::S_TRADE_A)
		else $error("second write-back of a trade skipped");
	a_trade_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::S_MATCH_DONE |-> ntr_q <= lobm_pkg::NTR_W'(lobm_pkg::TRADE_LIMIT))
		else $error("trade count beyond limit");
	a_trade_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lobm_pkg::S_TRADE_A |=> res_valid && !rep_q.last && rep_q.fill_quantity != '0)
		else $error("trade report malformed");

endmodule

// ===== rtl/core/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: front, engine and result queue.
// Depends on lobm_pkg, lobm_front, lobm_engine and lobm_resq.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   order    | push in, full out    | lobm_pkg::order_t order
//   report   | pop in, empty out    | lobm_pkg::report_t report
//
// One item at a time is worked in the engine; two more may wait in the front queue.
// Each search of the book reads the order memory once per slot. An add makes one search
// for a duplicate and a free slot and, once placed, one matching search per trade plus
// a last one; a cancel makes one search, and a modify makes one and then an add.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// A full result queue stalls the engine in place; the front takes transfers until full.
module limit_order_book_matcher #(
	parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lobm_pkg::order_t   order,
	output logic               empty,
	input  logic               pop,
	output lobm_pkg::report_t  report
);

	logic              cmd_valid, cmd_ready, res_valid, res_ready;
	lobm_pkg::cmd_t    cmd;
	lobm_pkg::report_t res;

	lobm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.order     (order),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	lobm_engine #(.MAX_ORDERS(MAX_ORDERS)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	lobm_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_ready  (res_ready),
		.in_report (res),
		.empty     (empty),
		.pop       (pop),
		.report    (report)
	);

endmodule

// ===== dv/limit_order_book_matcher_checker.sv =====
`timescale 1ns / 100ps
// Checker of the limit order book matcher: watches both channels, keeps its own book and compares.
// Depends on lobm_pkg for the payload structs, codes and limits.
module limit_order_book_matcher_checker #(
	parameter int MAX_ORDERS = lobm_pkg::MAX_ORDERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  lobm_pkg::order_t  order,
	input  logic              empty,
	input  logic              pop,
	input  lobm_pkg::report_t report,
	output int                errors,
	output int                pending
);

	logic              slot_live [MAX_ORDERS];
	lobm_pkg::entry_t  slot      [MAX_ORDERS];
	logic [31:0]       arrival_seq;
	lobm_pkg::report_t expected_reports [$];

	task automatic report_mismatch(input string what);
		$display("%0t: report mismatch: %s", $realtime, what);
		errors++;
	endtask

	task automatic queue_report(input lobm_pkg::report_t r);
		expected_reports.insert(expected_reports.size(), r);
	endtask

	function automatic lobm_pkg::report_t status_of(input logic [2:0] kind,
			input logic [31:0] id);
		lobm_pkg::report_t r;
		r = '0;
		r.kind = kind;
		r.bid_order_id = id;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic int slot_of_id(input logic [31:0] id);
		for (int i = 0; i < MAX_ORDERS; i++)
			if (slot_live[i] && slot[i].id == id) return i;
		return -1;
	endfunction

	// Best price wins; on a tie the order that has waited longest, counted modulo 2^32.
	function automatic int best_on(input logic sd);
		int b;
		logic better;
		b = -1;
		for (int i = 0; i < MAX_ORDERS; i++) begin
			if (!slot_live[i] || slot[i].side != sd) continue;
			if (b < 0) begin
				b = i;
				continue;
			end
			better = sd ? (slot[i].price < slot[b].price) : (slot[i].price > slot[b].price);
			if (better || (slot[i].price == slot[b].price &&
					(arrival_seq - slot[i].arrival) > (arrival_seq - slot[b].arrival)))
				b = i;
		end
		return b;
	endfunction

	task automatic place_order(input logic [31:0] id, input logic sd,
			input logic signed [31:0] px, input logic [23:0] qty, input logic fak);
		int o, fr, b, a, n;
		logic [23:0] q;
		lobm_pkg::report_t t;
		logic [2:0] kind;
		kind = lobm_pkg::KIND_ACCEPTED;
		n = 0;
		fr = -1;
		if (qty == 0) begin
			queue_report(status_of(lobm_pkg::KIND_INVALID, id));
			return;
		end
		if (slot_of_id(id) >= 0) begin
			queue_report(status_of(lobm_pkg::KIND_DUPLICATE, id));
			return;
		end
		if (fak) begin
			o = best_on(!sd);
			if (o < 0 || (sd ? (px > slot[o].price) : (px < slot[o].price))) begin
				queue_report(status_of(lobm_pkg::KIND_NO_CROSS, id));
				return;
			end
		end
		for (int i = 0; i < MAX_ORDERS; i++)
			if (!slot_live[i]) begin
				fr = i;
				break;
			end
		if (fr < 0) begin
			queue_report(status_of(lobm_pkg::KIND_INVALID, id));
			return;
		end
		slot_live[fr] = 1'b1;
		slot[fr] = '{id: id, side: sd, fak: fak, price: px, remaining: qty,
			arrival: arrival_seq};
		arrival_seq++;
		while (n < lobm_pkg::TRADE_LIMIT) begin
			b = best_on(1'b0);
			a = best_on(1'b1);
			if (b < 0 || a < 0 || slot[b].price < slot[a].price) break;
			q = (slot[b].remaining < slot[a].remaining) ? slot[b].remaining : slot[a].remaining;
			slot[b].remaining -= q;
			slot[a].remaining -= q;
			t = '0;
			t.kind = lobm_pkg::KIND_TRADE;
			t.bid_order_id = slot[b].id;
			t.ask_order_id = slot[a].id;
			t.bid_price = slot[b].price;
			t.ask_price = slot[a].price;
			t.fill_quantity = q;
			queue_report(t);
			n++;
			if (slot[b].remaining == 0) slot_live[b] = 1'b0;
			if (slot[a].remaining == 0) slot_live[a] = 1'b0;
		end
		if (slot_live[fr] && slot[fr].fak) begin
			slot_live[fr] = 1'b0;
			kind = lobm_pkg::KIND_CANCELLED;
		end
		queue_report(status_of(kind, id));
	endtask

	task automatic predict(input lobm_pkg::order_t it);
		int s;
		logic fk;
		if (it.action == lobm_pkg::ACT_ADD) begin
			place_order(it.order_id, it.side, it.price, it.quantity, it.order_type);
		end else if (it.action == lobm_pkg::ACT_CANCEL || it.action == lobm_pkg::ACT_MODIFY) begin
			s = slot_of_id(it.order_id);
			if (s < 0) begin
				queue_report(status_of(lobm_pkg::KIND_UNKNOWN, it.order_id));
			end else begin
				slot_live[s] = 1'b0;
				fk = slot[s].fak;
				if (it.action == lobm_pkg::ACT_CANCEL)
					queue_report(status_of(lobm_pkg::KIND_CANCELLED, it.order_id));
				else
					place_order(it.order_id, it.side, it.price, it.quantity, fk);
			end
		end else begin
			queue_report(status_of(lobm_pkg::KIND_INVALID, it.order_id));
		end
	endtask

	task automatic compare(input lobm_pkg::report_t got);
		lobm_pkg::report_t w;
		if (expected_reports.size() == 0) begin
			report_mismatch($sformatf("unexpected result %p", got));
			return;
		end
		w = expected_reports[0];
		expected_reports.delete(0);
		if (got.kind !== w.kind)
			report_mismatch($sformatf("kind %0d, want %0d", got.kind, w.kind));
		if (got.bid_order_id !== w.bid_order_id)
			report_mismatch($sformatf("bid id %h, want %h", got.bid_order_id, w.bid_order_id));
		if (got.ask_order_id !== w.ask_order_id)
			report_mismatch($sformatf("ask id %h, want %h", got.ask_order_id, w.ask_order_id));
		if (got.bid_price !== w.bid_price)
			report_mismatch($sformatf("bid price %0d, want %0d", got.bid_price, w.bid_price));
		if (got.ask_price !== w.ask_price)
			report_mismatch($sformatf("ask price %0d, want %0d", got.ask_price, w.ask_price));
		if (got.fill_quantity !== w.fill_quantity)
			report_mismatch($sformatf("fill %0d, want %0d", got.fill_quantity,
				w.fill_quantity));
		if (got.last !== w.last)
			report_mismatch($sformatf("last %b, want %b", got.last, w.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ORDERS; i++) slot_live[i] = 1'b0;
			arrival_seq = '0;
			expected_reports.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (push && !full) predict(order);
			if (pop && !empty) compare(report);
			pending = expected_reports.size();
		end
	end

endmodule

// ===== dv/limit_order_book_matcher_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the limit order book matcher: clock, reset, stimulus, watchdog and verdict.
// Depends on lobm_pkg, the block and limit_order_book_matcher_checker.
module limit_order_book_matcher_tb;

	localparam logic [1:0]        ACT_UNDEFINED = 2'd3;
	localparam logic signed [31:0] PRICE_MIN    = 32'sh8000_0000;
	localparam int                IDLE_LIMIT    = 30000;
	localparam int                RANDOM_ITEMS  = 340;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              pop = 1'b0;
	logic              full, empty;
	lobm_pkg::order_t  order = '0;
	lobm_pkg::report_t report;
	int                errors, pending;
	int                idle_cycles = 0;
	int                burst_base = 100000;

	always #5 clk = ~clk;

	limit_order_book_matcher DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .order(order),
		.empty(empty), .pop(pop), .report(report)
	);

	limit_order_book_matcher_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .order(order),
		.empty(empty), .pop(pop), .report(report), .errors(errors), .pending(pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sends one transfer on the order channel, with an optional idle gap first.
	// Full is sampled mid-cycle, where it holds the value seen at the next rising edge.
	task automatic send(input logic [1:0] act, input logic [31:0] id, input logic sd,
			input logic signed [31:0] px, input logic [23:0] qty, input logic fak,
			input int gap);
		logic taken;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push  <= 1'b1;
		order <= '{action: act, order_id: id, side: sd, price: px, quantity: qty,
			order_type: fak};
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_random();
		int r;
		logic [31:0] id;
		r = $urandom_range(0, 99);
		id = $urandom_range(1, 80);
		if (r < 62)
			send(lobm_pkg::ACT_ADD, id, 1'($urandom_range(0, 1)), $urandom_range(950, 1050),
				24'($urandom_range(1, 60)), $urandom_range(0, 99) < 20, pick_gap());
		else if (r < 78)
			send(lobm_pkg::ACT_CANCEL, id, 1'($urandom), $urandom, 24'($urandom),
				1'($urandom), pick_gap());
		else if (r < 90)
			send(lobm_pkg::ACT_MODIFY, id, 1'($urandom_range(0, 1)),
				$urandom_range(950, 1050), 24'($urandom_range(0, 60)), 1'($urandom),
				pick_gap());
		else if (r < 93)
			send(ACT_UNDEFINED, $urandom, 1'($urandom), $urandom, 24'($urandom),
				1'($urandom), pick_gap());
		else
			send(2'($urandom_range(0, 2)), $urandom, 1'($urandom), $urandom, 24'($urandom),
				1'($urandom), pick_gap());
	endtask

	// Fills the bid side with orders that cannot cross, past the book's capacity, then
	// sends one large sell at the lowest price, which finds no free slot in the full book.
	task automatic fill_and_sweep();
		for (int k = 0; k < lobm_pkg::MAX_ORDERS_DEF + 2; k++)
			send(lobm_pkg::ACT_ADD, burst_base + k, 1'b0, PRICE_MIN + $urandom_range(0, 20),
				24'($urandom_range(1, 9)), 1'b0, pick_gap());
		send(lobm_pkg::ACT_ADD, burst_base + 500, 1'b1, PRICE_MIN, 24'hFFFFFF, 1'b0,
			pick_gap());
		burst_base += 1000;
	endtask

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("limit_order_book_matcher_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed opening: statuses, a sweep with a fill-and-kill residue, time priority.
		send(lobm_pkg::ACT_ADD, 32'd1, 1'b0, 32'sd100, 24'd10, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd1, 1'b1, 32'sd50, 24'd5, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd2, 1'b1, 32'sd200, 24'd5, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd3, 1'b1, 32'sd90, 24'd4, 1'b0, 1);
		send(lobm_pkg::ACT_ADD, 32'd4, 1'b1, 32'sd100, 24'd20, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd5, 1'b0, 32'sd300, 24'd0, 1'b0, 0);
		send(lobm_pkg::ACT_CANCEL, 32'd77, 1'b0, 32'sd0, 24'd0, 1'b0, 0);
		send(lobm_pkg::ACT_MODIFY, 32'd78, 1'b1, 32'sd1, 24'd1, 1'b0, 2);
		send(ACT_UNDEFINED, 32'hFFFFFFFF, 1'b1, 32'sd2147483647, 24'hFFFFFF, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd0, 1'b0, 32'sd500, 24'd7, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'hFFFFFFFF, 1'b0, 32'sd500, 24'd7, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd6, 1'b1, 32'sd400, 24'd10, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd7, 1'b0, 32'sd2147483647, 24'hFFFFFF, 1'b0, 0);
		send(lobm_pkg::ACT_MODIFY, 32'd7, 1'b1, PRICE_MIN, 24'd3, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd8, 1'b1, PRICE_MIN, 24'hFFFFFF, 1'b0, 0);
		send(lobm_pkg::ACT_MODIFY, 32'd8, 1'b1, 32'sd5, 24'd0, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd9, 1'b1, 32'sd600, 24'd8, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd10, 1'b1, 32'sd700, 24'd8, 1'b0, 0);
		send(lobm_pkg::ACT_CANCEL, 32'd10, 1'b0, 32'sd0, 24'd0, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd11, 1'b0, -32'sd5, 24'd2, 1'b1, 0);
		send(lobm_pkg::ACT_ADD, 32'd12, 1'b1, -32'sd5, 24'd2, 1'b0, 0);
		// The first buy below takes the resting ask in full; the second rests and is then
		// hit by a larger sell, whose remainder stays in the book.
		send(lobm_pkg::ACT_ADD, 32'd13, 1'b0, 32'sd20, 24'd2, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd14, 1'b0, 32'sd20, 24'd2, 1'b0, 0);
		send(lobm_pkg::ACT_ADD, 32'd15, 1'b1, -32'sd10, 24'd3, 1'b0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 75) fill_and_sweep();
			if (n == RANDOM_ITEMS / 2) begin
				push <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			send_random();
		end
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("limit_order_book_matcher_tb: clean");
		else
			$display("limit_order_book_matcher_tb: errors");
		$finish;
	end

endmodule

// ===== limit_order_book_matcher.f =====
rtl/core/lobm_pkg.sv
rtl/core/lobm_front.sv
rtl/core/lobm_resq.sv
rtl/core/lobm_engine.sv
rtl/core/limit_order_book_matcher.sv
dv/limit_order_book_matcher_checker.sv
dv/limit_order_book_matcher_tb.sv
